[hdl/pqs_pkg.sv]
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared types and constants of the priority queue sorter.
// ----------------------------------------------------------------------------
package pqs_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_WIDTH  = 32;
    localparam int FIELD_W    = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [IDX_W-1:0]            idx_t;
    typedef logic [CNT_W-1:0]            cnt_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_FIRST,
        ST_DRAIN,
        ST_WAIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_key;    // capture incoming key
        logic clr_set;     // clear count and drop flag
        logic set_drop;    // mark a dropped key
        logic rd_en;       // issue store read
        logic wr_en;       // store write
        logic wr_new;      // write the new key instead of shifted data
        logic ptr_init;    // pointer to count
        logic ptr_zero;    // pointer to zero
        logic ptr_dec;
        logic ptr_inc;
        logic cnt_inc;
        logic out_load;    // load output register from read data
        logic out_last;
    } pqs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ptr_is_zero;
        logic full;
        logic rd_greater;  // read entry sorts after the new key
        logic ptr_at_end;  // pointer is last stored entry
        logic empty;
    } pqs_sts_t;

endpackage

[hdl/pqs_ram.sv]
// ----------------------------------------------------------------------------
// pqs_ram
// Generic simple dual-port RAM with one write and one registered read port.
// ----------------------------------------------------------------------------
module pqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/pqs_datapath.sv]
// ----------------------------------------------------------------------------
// pqs_datapath
// Key store, pointer, count, drop flag and output register.
// ----------------------------------------------------------------------------
module pqs_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pqs_pkg::pqs_cmd_t     cmd,
    output pqs_pkg::pqs_sts_t     sts,
    input  logic [31:0]           in_key,
    output logic [31:0]           out_key,
    output logic                  out_last,
    output logic                  out_drop
);
    import pqs_pkg::*;

    cnt_t cnt_reg, cnt_next;
    cnt_t ptr_reg, ptr_next;
    logic drop_reg, drop_next;
    key_t new_reg;
    key_t rd_data;
    idx_t rd_addr, wr_addr;
    key_t wr_data;
    logic [31:0] okey_reg;
    logic        olast_reg, odrop_reg;

    // read ptr-1 while searching; while draining, read zero or ptr+1, the pointer's next value
    always_comb
    begin
        if (cmd.ptr_zero || cmd.ptr_inc)
            rd_addr = cmd.ptr_zero ? '0 : ptr_reg[IDX_W-1:0] + idx_t'(1);
        else
            rd_addr = ptr_reg[IDX_W-1:0] - idx_t'(1);
    end

    assign wr_addr = ptr_reg[IDX_W-1:0];
    assign wr_data = cmd.wr_new ? new_reg : rd_data;

    pqs_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.clr_set)
            cnt_next = '0;
        else if (cmd.cnt_inc)
            cnt_next = cnt_reg + cnt_t'(1);
        ptr_next = ptr_reg;
        if (cmd.ptr_init)
            ptr_next = cnt_reg;
        else if (cmd.ptr_zero)
            ptr_next = '0;
        else if (cmd.ptr_dec)
            ptr_next = ptr_reg - cnt_t'(1);
        else if (cmd.ptr_inc)
            ptr_next = ptr_reg + cnt_t'(1);
        drop_next = drop_reg;
        if (cmd.set_drop)
            drop_next = 1'b1;
        else if (cmd.clr_set)
            drop_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ptr_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ptr_reg  <= ptr_next;
            drop_reg <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
            new_reg <= key_t'($signed(in_key));
        if (cmd.out_load)
        begin
            okey_reg  <= 32'($signed(rd_data));
            olast_reg <= cmd.out_last;
            odrop_reg <= drop_reg;
        end
    end

    assign sts.ptr_is_zero = (ptr_reg == '0);
    assign sts.full        = (cnt_reg == cnt_t'(CAPACITY));
    assign sts.rd_greater  = (rd_data > new_reg);
    assign sts.ptr_at_end  = (ptr_reg + cnt_t'(1) == cnt_reg);
    assign sts.empty       = (cnt_reg == '0);

    assign out_key  = okey_reg;
    assign out_last = olast_reg;
    assign out_drop = odrop_reg;

endmodule

[hdl/pqs_ctrl.sv]
// ----------------------------------------------------------------------------
// pqs_ctrl
// Sequencer for insertion search, shift and drain of the key store.
// ----------------------------------------------------------------------------
module pqs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pqs_pkg::pqs_cmd_t     cmd,
    input  pqs_pkg::pqs_sts_t     sts
);
    import pqs_pkg::*;

    state_t state_reg, state_next;
    logic   close_reg, close_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            close_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            close_reg <= close_next;
        end
    end

    always_comb
    begin
        logic take;
        state_next = state_reg;
        close_next = close_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        take       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_key = 1'b1;
                    close_next   = in_last;
                    if (sts.full)
                    begin
                        cmd.set_drop = 1'b1;
                        if (in_last)
                        begin
                            cmd.ptr_zero = 1'b1;
                            cmd.rd_en    = 1'b1;
                            state_next   = ST_DRAIN;
                        end
                    end
                    else
                    begin
                        cmd.ptr_init = 1'b1;
                        state_next   = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                // read entry just below the hole
                if (sts.ptr_is_zero)
                begin
                    take = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (sts.rd_greater)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.ptr_dec = 1'b1;
                    state_next  = ST_SEARCH;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            ST_FIRST:
            begin
                // new key is written, start reading from the bottom
                cmd.ptr_zero = 1'b1;
                cmd.rd_en    = 1'b1;
                state_next   = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // read data valid: load output
                cmd.out_load = 1'b1;
                cmd.out_last = sts.ptr_at_end;
                state_next   = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_ready)
                begin
                    if (sts.ptr_at_end)
                    begin
                        cmd.clr_set = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.ptr_inc = 1'b1;
                        state_next  = ST_DRAIN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (take)
        begin
            cmd.wr_en   = 1'b1;
            cmd.wr_new  = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (close_reg)
                state_next = ST_FIRST;
            else
                state_next = ST_IDLE;
        end
    end

    assign out_valid = (state_reg == ST_WAIT);

    // the drain never starts on an empty store: the closing word inserts or
    // meets a full store
    a_drain_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> !sts.empty)
        else $error("drain on empty store");

endmodule

[hdl/priority_queue_sorter.sv]
// ----------------------------------------------------------------------------
// priority_queue_sorter
// Sorts a set of signed keys by insertion into a store; drains ascending.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                    | tuser    | tlast
//  s_axis  | in  | key[31:0]                | -        | last_in
//  m_axis  | out | sorted_key[31:0]         | overflowed | last_out
//
//  an input word is placed by insertion: one read and one shift write per stored
//  key that sorts after it (the store has a single read and a single write port);
//  a word meeting a full store is dropped. the drain runs ST_FIRST, unless the
//  closing word met a full store, then ST_DRAIN (registered store read) and ST_WAIT
//  for each word; reset empties the set; stalls on m_axis hold the drain
// ----------------------------------------------------------------------------
module priority_queue_sorter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key
    input  logic        s_axis_tlast,   // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sorted_key
    output logic        m_axis_tuser,   // overflowed
    output logic        m_axis_tlast    // last_out
);
    import pqs_pkg::*;

    pqs_cmd_t cmd;
    pqs_sts_t sts;

    pqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    pqs_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_key   (s_axis_tdata),
        .out_key  (m_axis_tdata),
        .out_last (m_axis_tlast),
        .out_drop (m_axis_tuser)
    );

    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken during drain");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
        else $error("drain continues after last word");

    a_write_not_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !cmd.out_load)
        else $error("store written while draining");

endmodule

[bench/pqs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqs_checker
// Watches both stream channels of the sorter, keeps its own sorted store per
// set and compares every drained word with the predicted ascending key, last and overflow flag.
// ----------------------------------------------------------------------------
module pqs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    import pqs_pkg::*;

    typedef struct {
        logic [31:0] sorted_key;
        logic        last_out;
        logic        overflowed;
    } sorted_word_t;

    key_t         set_keys[$];
    logic         set_dropped;
    sorted_word_t sorted_words[$];

    // insert keeping ascending order, equal keys after earlier ones
    task automatic store_key(input key_t k);
        int pos;
        pos = set_keys.size();
        while (pos > 0 && set_keys[pos-1] > k)
            pos--;
        set_keys.insert(pos, k);
    endtask

    task automatic close_set();
        sorted_word_t w;
        foreach (set_keys[i])
        begin
            w.sorted_key = 32'(set_keys[i]);
            w.last_out   = (i == set_keys.size() - 1);
            w.overflowed = set_dropped;
            sorted_words = {sorted_words, w};
        end
        set_keys.delete();
        set_dropped = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            set_keys.delete();
            sorted_words.delete();
            set_dropped = 1'b0;
            pending     = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sorted_words.size() == 0)
                begin
                    $error("unexpected word: sorted_key %h", m_axis_tdata);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    sorted_word_t w;
                    w = sorted_words.pop_front();
                    if (m_axis_tdata !== w.sorted_key)
                    begin
                        $error("sorted_key expected %h actual %h", w.sorted_key, m_axis_tdata);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tlast !== w.last_out)
                    begin
                        $error("last_out expected %b actual %b", w.last_out, m_axis_tlast);
                        fail_count = fail_count + 1;
                    end
                    if (m_axis_tuser !== w.overflowed)
                    begin
                        $error("overflowed expected %b actual %b", w.overflowed, m_axis_tuser);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (set_keys.size() < CAPACITY)
                    store_key(key_t'(s_axis_tdata));
                else
                    set_dropped = 1'b1;
                if (s_axis_tlast)
                    close_set();
            end
            pending = sorted_words.size();
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the priority queue sorter: directed sets with extreme keys,
// duplicates and overflow, then random sets with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
    import pqs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;
    bit          hold_drain = 1'b0;
    bit          hold_done = 1'b0;

    always #6 clk = ~clk;

    priority_queue_sorter u_dut (.*);

    pqs_checker u_chk (.*);

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 7)) - 32'd4;
            default: return $urandom();
        endcase
    endfunction

    // offer one word and hold it until accepted
    task automatic send_word(input logic [31:0] k, input logic lst, input bit may_gap);
        int g;
        g = may_gap ? gap_len() : 0;
        repeat (g)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= k;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_set(input int n, input bit may_gap);
        for (int i = 0; i < n; i++)
            send_word(rand_key(), i == n - 1, may_gap);
    endtask

    // receiver: random stalls, sometimes none at all, one long hold on request
    initial
    begin
        int g;
        bit quiet;
        @(posedge rst_n);
        forever
        begin
            quiet = ($urandom_range(0, 3) == 0);
            repeat (50)
            begin
                if (hold_drain && !hold_done)
                begin
                    // hold off from the first drained word for a long stretch
                    m_axis_tready <= 1'b0;
                    @(posedge clk);
                    while (!m_axis_tvalid)
                        @(posedge clk);
                    repeat (300) @(posedge clk);
                    hold_done = 1'b1;
                end
                else
                begin
                    g = quiet ? 0 : gap_len();
                    if (g > 0)
                    begin
                        m_axis_tready <= 1'b0;
                        repeat (g) @(posedge clk);
                    end
                    m_axis_tready <= 1'b1;
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int sent;
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single key set, extremes, duplicates
        send_word(32'h8000_0000, 1'b1, 0);
        send_word(32'h7fff_ffff, 1'b0, 0);
        send_word(32'h8000_0000, 1'b0, 0);
        send_word(32'hffff_ffff, 1'b0, 0);
        send_word(32'h0000_0000, 1'b0, 0);
        send_word(32'h7fff_ffff, 1'b0, 0);
        send_word(32'h0000_0001, 1'b1, 0);
        for (int i = 0; i < 12; i++)
            send_word(32'h5555_aaaa ^ {32{i[0]}}, i == 11, 0);

        // overflow: drain held off so the block stalls its input too
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        hold_drain = 1'b1;
        for (int i = 0; i < CAPACITY + 3; i++)
            send_word($urandom(), i == CAPACITY + 2, 0);
        send_set(5, 0);

        sent = 0;
        while (sent < 230)
        begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
            send_set(n, 1);
            sent += n;
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("priority_queue_sorter: match");
        else
            $display("priority_queue_sorter: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("priority_queue_sorter: mismatch");
        $finish;
    end

endmodule
